// ===== hdl/rqrs_pkg.sv =====
// Shared types and constants for the ray quadratic root solver.
// No dependencies; imported by every module of the block but rqrs_check.
package rqrs_pkg;

  localparam int FRAC_BITS_DEF = 16;   // default fraction bits of Q formats
  localparam int CW            = 32;   // coefficient and distance width
  localparam int DW            = 67;   // signed discriminant width
  localparam int SW            = 33;   // square root width
  localparam int RW            = 35;   // signed root numerator width

  // Per-request fields carried alongside the discriminant and root
  typedef struct packed {
    logic                 mode;
    logic                 ok;      // real roots and a usable leading term
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
  } side_t;

  // One finished result
  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] near_dist;
    logic signed [CW-1:0] far_dist;
    logic                 near_facing;
    logic                 far_facing;
  } res_t;

endpackage

// ===== hdl/rqrs_front.sv =====
// Front end: coefficient products and the exact discriminant, two stages.
// Depends on rqrs_pkg.
module rqrs_front import rqrs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic                 mode,
  input  logic signed [CW-1:0] coef_a,
  input  logic signed [CW-1:0] coef_b,
  input  logic signed [CW-1:0] coef_c,
  output logic                 out_valid,
  output side_t                out_side,
  output logic [DW-2:0]        disc
);

  logic                   v1;
  logic                   mode1;
  logic signed [CW-1:0]   a1, b1, c1;
  logic signed [2*CW-1:0] bb1, ac1;
  logic signed [DW-1:0]   cs_w, ac4_w, d_w;
  side_t                  side_w;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // Stage 1: b*b and a*c
  always_ff @(posedge clk) begin
    if (en) begin
      mode1 <= mode;
      a1    <= coef_a;
      b1    <= coef_b;
      c1    <= coef_c;
      bb1   <= coef_b * coef_b;
      ac1   <= coef_a * coef_c;
    end
  end

  // Stage 2: D = b*b - 4ac, or b*b - c*one in half-b form
  always_comb begin
    cs_w        = DW'(c1) <<< FRAC_BITS;
    ac4_w       = DW'(ac1) <<< 2;
    d_w         = DW'(bb1) - (mode1 ? cs_w : ac4_w);
    side_w.mode = mode1;
    side_w.ok   = !d_w[DW-1] && (mode1 || (a1 != '0));
    side_w.a    = a1;
    side_w.b    = b1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side_w;
      disc     <= d_w[DW-2:0];
    end
  end

endmodule

// ===== hdl/rqrs_sqrt.sv =====
// Pipelined digit-by-digit floor square root, one root bit per stage.
// Depends on rqrs_pkg.
module rqrs_sqrt import rqrs_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  side_t         in_side,
  input  logic [DW-2:0] disc,
  output logic          out_valid,
  output side_t         out_side,
  output logic [SW-1:0] root
);

  localparam int STEPS = SW;          // one radicand bit pair per stage
  localparam int RMW   = SW + 1;      // remainder stays below 2*root+1
  localparam int TW    = RMW + 2;

  logic          v_q    [0:STEPS-1];
  side_t         side_q [0:STEPS-1];
  logic [DW-2:0] d_q    [0:STEPS-1];
  logic [RMW-1:0] rem_q [0:STEPS-1];
  logic [SW-1:0] root_q [0:STEPS-1];

  side_t          side_n [0:STEPS-1];
  logic [DW-2:0]  d_n    [0:STEPS-1];
  logic [RMW-1:0] rem_n  [0:STEPS-1];
  logic [SW-1:0]  root_n [0:STEPS-1];

  // Each stage brings down the top bit pair and tries 4*root+1
  always_comb begin
    logic [DW-2:0]  pd;
    logic [RMW-1:0] pr;
    logic [SW-1:0]  pq;
    logic [TW-1:0]  t;
    logic [TW-1:0]  trial;
    logic           ge;
    for (int k = 0; k < STEPS; k++) begin
      if (k == 0) begin
        pd = disc;
        pr = '0;
        pq = '0;
        side_n[k] = in_side;
      end else begin
        pd = d_q[k-1];
        pr = rem_q[k-1];
        pq = root_q[k-1];
        side_n[k] = side_q[k-1];
      end
      t         = {pr, pd[DW-2 -: 2]};
      trial     = TW'({pq, 2'b01});
      ge        = (t >= trial);
      rem_n[k]  = ge ? RMW'(t - trial) : RMW'(t);
      root_n[k] = {pq[SW-2:0], ge};
      d_n[k]    = pd << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STEPS; k++) v_q[k] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid;
      for (int k = 1; k < STEPS; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < STEPS; k++) begin
        side_q[k] <= side_n[k];
        d_q[k]    <= d_n[k];
        rem_q[k]  <= rem_n[k];
        root_q[k] <= root_n[k];
      end
    end
  end

  assign out_valid = v_q[STEPS-1];
  assign out_side  = side_q[STEPS-1];
  assign root      = root_q[STEPS-1];

endmodule

// ===== hdl/rqrs_div.sv =====
// Root forming, hit and facing decisions, two pipelined floor dividers
// (one quotient bit per stage) and saturation. Depends on rqrs_pkg.
module rqrs_div import rqrs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  side_t         in_side,
  input  logic [SW-1:0] root,
  output logic          out_valid,
  output res_t          res
);

  localparam int MW  = RW - 1;          // numerator magnitude width
  localparam int NW  = MW + FRAC_BITS;  // scaled numerator width
  localparam int QW  = CW;              // quotient bits
  localparam int DMW = CW + 1;          // |2a|
  localparam int OCW = DMW + QW + 1;    // overflow compare width

  typedef struct packed {
    logic           neg;
    logic           ovf;
    logic [MW-1:0]  rem;
    logic [QW-1:0]  q;
    logic [QW-1:0]  low;
  } lane_t;

  typedef struct packed {
    logic                 mode;
    logic                 hit;
    logic                 nf;
    logic signed [RW-1:0] nn;
    logic signed [RW-1:0] fn;
    logic [DMW-1:0]       dmag;
  } dctl_t;

  // Stage R1: numerators -b -/+ s, ordered by the sign of a unless in half-b form
  logic                 v1;
  logic                 mode1, ok1;
  logic signed [CW-1:0] a1;
  logic signed [RW-1:0] nn1, fn1;
  logic signed [RW-1:0] s_w, nb_w, lo_w, hi_w;

  always_comb begin
    s_w  = $signed({{(RW-SW){1'b0}}, root});
    nb_w = -RW'(in_side.b);
    lo_w = nb_w - s_w;
    hi_w = nb_w + s_w;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1 <= in_side.mode;
      ok1   <= in_side.ok;
      a1    <= in_side.a;
      nn1   <= (!in_side.mode && in_side.a[CW-1]) ? hi_w : lo_w;
      fn1   <= (!in_side.mode && in_side.a[CW-1]) ? lo_w : hi_w;
    end
  end

  // Stage R2: signs against the denominator, magnitudes
  logic           v2;
  dctl_t          ctl2;
  logic [MW-1:0]  nmag2, fmag2;
  logic           nneg2, fneg2;
  logic           dsgn_w, nz_n, nz_f, near_pos, far_pos, far_neg;
  logic [CW-1:0]  amag_w;

  always_comb begin
    dsgn_w   = !mode1 && a1[CW-1];
    nz_n     = (nn1 != '0);
    nz_f     = (fn1 != '0);
    near_pos = nz_n && (nn1[RW-1] == dsgn_w);
    far_pos  = nz_f && (fn1[RW-1] == dsgn_w);
    far_neg  = nz_f && (fn1[RW-1] != dsgn_w);
    amag_w   = a1[CW-1] ? CW'(-a1) : CW'(a1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl2.mode <= mode1;
      ctl2.hit  <= ok1 && !far_neg;
      ctl2.nf   <= !near_pos && far_pos;
      ctl2.nn   <= nn1;
      ctl2.fn   <= fn1;
      ctl2.dmag <= {amag_w, 1'b0};
      nmag2     <= nn1[RW-1] ? MW'(-nn1) : MW'(nn1);
      fmag2     <= fn1[RW-1] ? MW'(-fn1) : MW'(fn1);
      nneg2     <= nn1[RW-1] ^ dsgn_w;
      fneg2     <= fn1[RW-1] ^ dsgn_w;
    end
  end

  // Overflow check and divider start
  function automatic lane_t lane_init(logic [MW-1:0] mag, logic [DMW-1:0] d, logic neg);
    logic [NW-1:0] nfull;
    lane_t         l;
    nfull = {mag, {FRAC_BITS{1'b0}}};
    l.neg = neg;
    l.ovf = (OCW'(nfull) >= OCW'({d, {QW{1'b0}}}));
    l.rem = MW'(nfull >> QW);
    l.q   = '0;
    l.low = nfull[QW-1:0];
    return l;
  endfunction

  // One restoring division step
  function automatic lane_t lane_step(lane_t l, logic [DMW-1:0] d);
    logic [MW-1:0] t;
    logic          ge;
    lane_t         r;
    t     = {l.rem[MW-2:0], l.low[QW-1]};
    ge    = (t >= MW'(d));
    r     = l;
    r.rem = ge ? (t - MW'(d)) : t;
    r.q   = {l.q[QW-2:0], ge};
    r.low = l.low << 1;
    return r;
  endfunction

  // Floor of the signed quotient, saturated
  function automatic logic [CW-1:0] lane_final(lane_t l);
    logic [QW:0]   m;
    logic [CW-1:0] r;
    m = {1'b0, l.q} + (QW+1)'(l.rem != '0);
    if (!l.neg) begin
      r = (l.ovf || l.q[QW-1]) ? {1'b0, {(CW-1){1'b1}}} : l.q;
    end else if (l.ovf || (m > {2'b01, {(QW-1){1'b0}}})) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = CW'((QW+1)'(0) - m);
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] sat_root(logic signed [RW-1:0] v);
    logic [CW-1:0] r;
    if (v[RW-1:CW-1] == '0 || v[RW-1:CW-1] == '1) r = CW'(v);
    else if (v[RW-1])                                r = {1'b1, {(CW-1){1'b0}}};
    else                                             r = {1'b0, {(CW-1){1'b1}}};
    return r;
  endfunction

  // Divider stages; entry 0 holds the start values
  logic  vq [0:QW];
  dctl_t cq [0:QW];
  lane_t lnq [0:QW];
  lane_t lfq [0:QW];
  lane_t lnn [0:QW];
  lane_t lfn [0:QW];

  always_comb begin
    lnn[0] = lane_init(nmag2, ctl2.dmag, nneg2);
    lfn[0] = lane_init(fmag2, ctl2.dmag, fneg2);
    for (int k = 1; k <= QW; k++) begin
      lnn[k] = lane_step(lnq[k-1], cq[k-1].dmag);
      lfn[k] = lane_step(lfq[k-1], cq[k-1].dmag);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cq[0]  <= ctl2;
      lnq[0] <= lnn[0];
      lfq[0] <= lfn[0];
      for (int k = 1; k <= QW; k++) begin
        cq[k]  <= cq[k-1];
        lnq[k] <= lnn[k];
        lfq[k] <= lfn[k];
      end
    end
  end

  // Valid bits of every stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k <= QW; k++) vq[k] <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      v2    <= v1;
      vq[0] <= v2;
      for (int k = 1; k <= QW; k++) vq[k] <= vq[k-1];
      out_valid <= vq[QW];
    end
  end

  // Final stage: pick root source, clear fields on a miss
  res_t res_w;

  always_comb begin
    res_w.hit         = cq[QW].hit;
    res_w.near_dist   = '0;
    res_w.far_dist    = '0;
    res_w.near_facing = cq[QW].hit && cq[QW].nf;
    res_w.far_facing  = cq[QW].hit;
    if (cq[QW].hit) begin
      if (cq[QW].mode) begin
        res_w.near_dist = sat_root(cq[QW].nn);
        res_w.far_dist  = sat_root(cq[QW].fn);
      end else begin
        res_w.near_dist = lane_final(lnq[QW]);
        res_w.far_dist  = lane_final(lfq[QW]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) res <= res_w;
  end

endmodule

// ===== hdl/ray_quadratic_root_solver.sv =====
// Top level of the ray quadratic root solver: front end, square root,
// dividers and a two-entry output buffer. Depends on rqrs_pkg and submodules.
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  ---------+-----+---------------------------------------------+------
//  s_axis   | in  | coef_a, coef_b, coef_c                      | mode
//  m_axis   | out | near_dist, far_dist, near_facing, far_facing | hit
//
// One request per cycle unless stalled; a result passes 2 product/discriminant
// stages, 33 square root stages, 36 root/divide stages and 1 output buffer.
// The depth is set by the bit-per-stage root and quotient pipelines. rst
// clears all valid bits and the buffer. The pipeline stalls only when its
// last stage is full and both buffer entries are held.
module ray_quadratic_root_solver import rqrs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // coef_a[31:0], coef_b[63:32], coef_c[95:64]
  input  logic        s_tuser,   // mode[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // near_dist[31:0], far_dist[63:32],
                                 // near_facing[64], far_facing[65], zero pad
  output logic        m_tuser    // hit[0]
);

  logic          en;
  logic          f_valid, q_valid, d_valid;
  side_t         f_side, q_side;
  logic [DW-2:0] f_disc;
  logic [SW-1:0] q_root;
  res_t          d_res;

  rqrs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .mode      (s_tuser),
    .coef_a    ($signed(s_tdata[31:0])),
    .coef_b    ($signed(s_tdata[63:32])),
    .coef_c    ($signed(s_tdata[95:64])),
    .out_valid (f_valid),
    .out_side  (f_side),
    .disc      (f_disc)
  );

  rqrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_side   (f_side),
    .disc      (f_disc),
    .out_valid (q_valid),
    .out_side  (q_side),
    .root      (q_root)
  );

  rqrs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_valid),
    .in_side   (q_side),
    .root      (q_root),
    .out_valid (d_valid),
    .res       (d_res)
  );

  // Two-entry output buffer; pipeline moves unless it would overflow
  logic [1:0] cnt;
  res_t       buf0, buf1;
  logic       push, pop;

  assign en       = !d_valid || (cnt != 2'd2);
  assign s_tready = en;
  assign push     = en && d_valid;
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    priority if (push && !pop) begin
      if (cnt == 2'd0) buf0 <= d_res;
      else             buf1 <= d_res;
    end else if (pop && !push) begin
      buf0 <= buf1;
    end else if (push && pop) begin
      if (cnt == 2'd1) begin
        buf0 <= d_res;
      end else begin
        buf0 <= buf1;
        buf1 <= d_res;
      end
    end
  end

  assign m_tvalid = (cnt != 2'd0);
  assign m_tuser  = buf0.hit;
  assign m_tdata  = {6'd0, buf0.far_facing, buf0.near_facing,
                     buf0.far_dist, buf0.near_dist};

endmodule

// ===== hdl/rqrs_check.sv =====
// Port-level checks of the ray quadratic root solver results.
// Attached to the top level by the bind statement at the end.
module rqrs_check (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        m_tuser
);

  // A miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 72'd0)
    else $error("miss with nonzero fields");

  // A hit always faces inwards at the far root
  a_far_facing: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[65])
    else $error("hit without far facing");

  // Roots come out ordered
  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> $signed(m_tdata[31:0]) <= $signed(m_tdata[63:32]))
    else $error("near root above far root");

  // Inward near facing means the far root lies ahead
  a_inside: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser && m_tdata[64] |-> !m_tdata[63])
    else $error("inward facing with negative far root");

  // A held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

endmodule

bind ray_quadratic_root_solver rqrs_check u_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/sv/ray_quadratic_root_solver_tb.sv =====
// Testbench for the ray quadratic root solver: directed and random requests,
// a bit-exact root predictor and an in-order result checker.
// Depends on rqrs_pkg and the ray_quadratic_root_solver RTL.
`timescale 1ns / 100ps

module ray_quadratic_root_solver_tb import rqrs_pkg::*; ;

  localparam int FB = FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;   // coef_a[31:0], coef_b[63:32], coef_c[95:64]
  logic        s_tuser;   // mode[0]
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;   // near_dist[31:0], far_dist[63:32], near_facing[64], far_facing[65]
  logic        m_tuser;   // hit[0]

  res_t        pending_roots[$];
  int          src_idle_pct;
  int          snk_idle_pct;
  int          n_errors;
  int          n_requests;
  int          n_results;
  int          n_hits;
  int          idle_cycles;

  ray_quadratic_root_solver uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // floor square root of a 67-bit unsigned value, one result bit per pass
  function automatic logic [32:0] floor_sqrt(input logic [66:0] v);
    logic [33:0] root;
    logic [68:0] rem;
    logic [68:0] trial;
    logic [67:0] x;
    x = {1'b0, v};
    root = '0;
    rem = '0;
    for (int i = 33; i >= 0; i--) begin
      rem = (rem << 2) | x[2*i +: 2];
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        root = {root[32:0], 1'b1};
      end else begin
        root = {root[32:0], 1'b0};
      end
    end
    return root[32:0];
  endfunction

  function automatic logic signed [127:0] div_floor(input logic signed [127:0] n,
                                                    input logic signed [127:0] d);
    logic signed [127:0] q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic int sign_of(input logic signed [127:0] v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // expected result for one request
  function automatic res_t solve_roots(input logic mode, input logic signed [31:0] a,
                                       input logic signed [31:0] b,
                                       input logic signed [31:0] c);
    res_t r;
    logic signed [127:0] aa, bb, cc, disc, s, den, nn, fn, near_v, far_v;
    int near_s, far_s;
    r = '0;
    aa = a; bb = b; cc = c;
    if (mode == 1'b0) begin
      if (a == 0) return r;
      disc = bb * bb - 4 * aa * cc;
      if (disc < 0) return r;
      s = floor_sqrt(disc[66:0]);
      den = 2 * aa;
      if (aa > 0) begin
        nn = -bb - s; fn = -bb + s;
      end else begin
        nn = -bb + s; fn = -bb - s;
      end
      near_s = sign_of(nn) * sign_of(den);
      far_s = sign_of(fn) * sign_of(den);
      near_v = div_floor(nn <<< FB, den);
      far_v = div_floor(fn <<< FB, den);
    end else begin
      disc = bb * bb - (cc <<< FB);
      if (disc < 0) return r;
      s = floor_sqrt(disc[66:0]);
      near_v = -bb - s;
      far_v = -bb + s;
      near_s = sign_of(near_v);
      far_s = sign_of(far_v);
    end
    if (far_s < 0) return r;
    r.hit = 1'b1;
    r.near_dist = clamp32(near_v);
    r.far_dist = clamp32(far_v);
    r.near_facing = (near_s > 0) ? 1'b0 : ((far_s > 0) ? 1'b1 : 1'b0);
    r.far_facing = 1'b1;
    return r;
  endfunction

  // send one request, with random idle cycles before it; returns at a
  // falling edge with tvalid still high, the next call or the caller drops it
  task automatic send_request(input logic mode, input logic [31:0] a,
                              input logic [31:0] b, input logic [31:0] c);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {c, b, a};
    s_tuser <= mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_roots.push_back(solve_roots(mode, a, b, c));
    n_requests++;
    @(negedge clk);
  endtask

  // receiver backpressure
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected result tuser=%b tdata=%h", $time, m_tuser, m_tdata);
        n_errors++;
      end else begin
        want = pending_roots.pop_front();
        if (want.hit) n_hits++;
        if (m_tuser !== want.hit || m_tdata[31:0] !== want.near_dist ||
            m_tdata[63:32] !== want.far_dist || m_tdata[64] !== want.near_facing ||
            m_tdata[65] !== want.far_facing || m_tdata[71:66] !== 6'd0) begin
          $display("%0t: mismatch expected hit=%b near=%h far=%h nf=%b ff=%b", $time,
                   want.hit, want.near_dist, want.far_dist, want.near_facing,
                   want.far_facing);
          $display("%0t:          actual   hit=%b near=%h far=%h nf=%b ff=%b pad=%h",
                   $time, m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[64],
                   m_tdata[65], m_tdata[71:66]);
          n_errors++;
        end
      end
    end
  end

  // watchdog: cycles with no request or result accepted
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[ray_quadratic_root_solver] ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] q_int(input int v);
    return v <<< FB;
  endfunction

  // extremes, zero a, both modes, facing and saturation cases
  task automatic test_directed();
    send_request(1'b0, 32'h0, q_int(2), q_int(-1));        // zero a
    send_request(1'b0, q_int(1), q_int(-3), q_int(2));     // roots 1, 2
    send_request(1'b0, q_int(1), q_int(1), q_int(-2));     // roots -2, 1: inward
    send_request(1'b0, q_int(1), q_int(3), q_int(2));      // both negative
    send_request(1'b0, q_int(1), 32'h0, q_int(1));         // negative disc
    send_request(1'b0, q_int(1), 32'h0, 32'h0);            // double zero root
    send_request(1'b0, q_int(-1), q_int(3), q_int(-2));    // negative a
    send_request(1'b0, q_int(1), q_int(2), 32'h0);         // roots -2, 0
    send_request(1'b0, 32'h1, 32'h7fffffff, 32'h80000000); // saturating
    send_request(1'b0, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_request(1'b0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_request(1'b0, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_request(1'b0, 32'hffffffff, 32'h1, 32'h80000000);
    send_request(1'b1, 32'h0, q_int(-3), q_int(5));        // half-b: roots 1, 5
    send_request(1'b1, 32'hdeadbeef, q_int(1), q_int(-3)); // a ignored, inward
    send_request(1'b1, 32'h0, q_int(3), q_int(5));         // both negative
    send_request(1'b1, 32'h0, 32'h0, q_int(1));            // negative disc
    send_request(1'b1, 32'h0, 32'h0, 32'h0);               // double zero
    send_request(1'b1, 32'h0, 32'h80000000, 32'h80000000); // saturating
    send_request(1'b1, 32'h0, 32'h7fffffff, 32'h7fffffff);
    send_request(1'b1, 32'h0, 32'h80000000, 32'h7fffffff);
    send_request(1'b1, 32'h0, 32'h7fffffff, 32'h80000000);
  endtask

  // random requests, mostly with small coefficients so that hits are common
  task automatic test_random(input int count);
    logic [31:0] a, b, c;
    logic mode;
    for (int i = 0; i < count; i++) begin
      mode = 1'($urandom_range(1));
      case ($urandom_range(3))
        0: begin
          a = $urandom; b = $urandom; c = $urandom;
        end
        1: begin
          a = $signed($urandom_range(32'h40000)) - 32'sh20000;
          b = $signed($urandom_range(32'h100000)) - 32'sh80000;
          c = $signed($urandom_range(32'h100000)) - 32'sh80000;
        end
        default: begin
          a = $signed($urandom_range(32'h1000000)) - 32'sh800000;
          b = $signed($urandom_range(32'h4000000)) - 32'sh2000000;
          c = $signed($urandom_range(32'h4000000)) - 32'sh2000000;
          if ($urandom_range(1)) c = -$signed(c) * $signed(a[31] ? -1 : 1);
        end
      endcase
      send_request(mode, a, b, c);
    end
  endtask

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    rst = 1'b1;
    n_errors = 0; n_requests = 0; n_results = 0; n_hits = 0;
    src_idle_pct = 6;
    snk_idle_pct = 47;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(600);
    src_idle_pct = 47;
    snk_idle_pct = 6;
    test_random(600);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(600);
    s_tvalid <= 1'b0;

    // drain
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d requests in both modes, checked %0d results, %0d of them hits,",
             n_requests, n_results, n_hits);
    $display("under three sender and receiver idle mixes; %0d errors.", n_errors);
    if (n_errors == 0 && pending_roots.size() == 0) begin
      $display("[ray_quadratic_root_solver] OK");
    end else begin
      $display("[ray_quadratic_root_solver] ERROR");
    end
    $finish;
  end

endmodule
